/* design/cxw_pkg.sv */
// Shared package of the CIE 1931 matching weight interpolator: the tabulated curves,
// the ROM word rounding function, the field widths and the stage-advance struct.
// No dependencies.
package cxw_pkg;

	localparam int CXW_WAVE_FRAC_BITS_DEF   = 4;
	localparam int CXW_WEIGHT_FRAC_BITS_DEF = 14;

	localparam int CXW_WAVE_W     = 16;
	localparam int CXW_WEIGHT_W   = 15;
	localparam int CXW_WEIGHT_MAX = 32767;
	localparam int CXW_TDATA_W    = 48;

	localparam int CXW_BAND_LOW_NM    = 380;
	localparam int CXW_BAND_HIGH_NM   = 780;
	localparam int CXW_STEP_NM        = 5;
	localparam int CXW_LAST_INTERVAL  = 81 - 1;
	localparam int CXW_ENTRIES        = CXW_LAST_INTERVAL + 1;
	localparam int CXW_IDX_W          = $clog2(CXW_ENTRIES);
	// Whole-nanometre offset into the band: 0 .. 399.
	localparam int CXW_NM_OFF_W       = $clog2(CXW_BAND_HIGH_NM - CXW_BAND_LOW_NM);

	localparam int CXW_NSTAGE = 8;

	localparam int CXW_CH_X = 0;
	localparam int CXW_CH_Y = 1;
	localparam int CXW_CH_Z = 2;
	localparam int CXW_NCH  = 3;

	// Matching values in units of 1e-4, 380 nm to 780 nm in 5 nm steps.
	localparam logic [14:0] CXW_CMF [CXW_NCH][CXW_ENTRIES] = '{
		'{
			14, 22, 42, 76, 143, 232, 435, 776, 1344, 2148,
			2839, 3285, 3483, 3481, 3362, 3187, 2908, 2511, 1954, 1421,
			956, 580, 320, 147, 49, 24, 93, 291, 633, 1096,
			1655, 2257, 2904, 3597, 4334, 5121, 5945, 6784, 7621, 8425,
			9163, 9786, 10263, 10567, 10622, 10456, 10026, 9384, 8544, 7514,
			6424, 5419, 4479, 3608, 2835, 2187, 1649, 1212, 874, 636,
			468, 329, 227, 158, 114, 81, 58, 41, 29, 20,
			14, 10, 7, 5, 3, 2, 2, 1, 1, 1,
			0
		},
		'{
			0, 1, 1, 2, 4, 6, 12, 22, 40, 73,
			116, 168, 230, 298, 380, 480, 600, 739, 910, 1126,
			1390, 1693, 2080, 2586, 3230, 4073, 5030, 6082, 7100, 7932,
			8620, 9149, 9540, 9803, 9950, 10000, 9950, 9786, 9520, 9154,
			8700, 8163, 7570, 6949, 6310, 5668, 5030, 4412, 3810, 3210,
			2650, 2170, 1750, 1382, 1070, 816, 610, 446, 320, 232,
			170, 119, 82, 57, 41, 29, 21, 15, 10, 7,
			5, 4, 2, 2, 1, 1, 1, 0, 0, 0,
			0
		},
		'{
			65, 105, 201, 362, 679, 1102, 2074, 3713, 6456, 10391,
			13856, 16230, 17471, 17826, 17721, 17441, 16692, 15281, 12876, 10419,
			8130, 6162, 4652, 3533, 2720, 2123, 1582, 1117, 782, 573,
			422, 298, 203, 134, 87, 57, 39, 27, 21, 18,
			17, 14, 11, 10, 8, 6, 3, 2, 2, 1,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			0
		}
	};

	// Tabulated value rounded to frac_bits fraction bits, ties up.
	// Only ever called with constant arguments, so it folds into ROM contents.
	function automatic logic [31:0] cxw_rom_word(input logic [14:0] t, input int frac_bits);
		longint unsigned v;
		v = ((longint'(t) << frac_bits) + 64'd5000) / 64'd10000;
		return 32'(v);
	endfunction

	// Load strobes of the lane stages four to eight.
	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} cxw_adv_t;

endpackage

/* design/cxw_lane.sv */
// One color channel of the interpolator: ROM lookup of both interval ends, the two
// weighted products, the rounded division by the interval span and saturation.
// Depends on cxw_pkg.
module cxw_lane #(
	parameter int WAVE_FRAC_BITS   = cxw_pkg::CXW_WAVE_FRAC_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = cxw_pkg::CXW_WEIGHT_FRAC_BITS_DEF,
	parameter int CHANNEL          = cxw_pkg::CXW_CH_X
) (
	input  logic                              clk,
	input  cxw_pkg::cxw_adv_t                 adv,
	input  logic [cxw_pkg::CXW_IDX_W-1:0]     idx,
	input  logic [WAVE_FRAC_BITS+2:0]         d,
	output logic [cxw_pkg::CXW_WEIGHT_W-1:0]  weight
);
	import cxw_pkg::*;

	localparam int ROM_W = WEIGHT_FRAC_BITS + 1;
	localparam int D_W   = WAVE_FRAC_BITS + 3;
	localparam int SPAN  = CXW_STEP_NM << WAVE_FRAC_BITS;
	localparam int HALF  = SPAN / 2;
	localparam int P_W   = ROM_W + D_W;
	localparam int SUM_W = P_W + 1;
	localparam int X_W   = SUM_W - WAVE_FRAC_BITS;
	// floor(x / 5) = (x * RECIP) >> (X_W + 3), exact for every x below 2**X_W.
	localparam int M_W   = X_W + 1;
	localparam int SH    = X_W + 3;
	localparam longint unsigned RECIP = ((64'd1 << SH) + 64'd4) / 64'd5;
	localparam int PR_W  = X_W + M_W;
	localparam int Q_W   = PR_W - SH;
	localparam int CMP_W = (Q_W > CXW_WEIGHT_W) ? Q_W : CXW_WEIGHT_W;

	logic [ROM_W-1:0] rom [CXW_ENTRIES];

	for (genvar g = 0; g < CXW_ENTRIES; g++) begin : g_rom
		assign rom[g] = ROM_W'(cxw_rom_word(CXW_CMF[CHANNEL][g], WEIGHT_FRAC_BITS));
	end

	logic [ROM_W-1:0]        a_s4, b_s4;
	logic [D_W-1:0]          d_s4;
	logic [P_W-1:0]          pa_s5, pb_s5;
	logic [X_W-1:0]          x_s6;
	logic [PR_W-1:0]         prod_s7;
	logic [CXW_WEIGHT_W-1:0] weight_s8;
	logic [Q_W-1:0]          quot;

	assign quot = Q_W'(prod_s7 >> SH);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			a_s4 <= rom[idx];
			b_s4 <= rom[idx + CXW_IDX_W'(1)];
			d_s4 <= d;
		end
		if (adv.s5) begin
			pa_s5 <= P_W'(a_s4) * P_W'(D_W'(SPAN) - d_s4);
			pb_s5 <= P_W'(b_s4) * P_W'(d_s4);
		end
		if (adv.s6) begin
			// The span is five times a power of two: drop the power here, divide by five next.
			x_s6 <= X_W'((SUM_W'(pa_s5) + SUM_W'(pb_s5) + SUM_W'(HALF)) >> WAVE_FRAC_BITS);
		end
		if (adv.s7) begin
			prod_s7 <= PR_W'(x_s6) * PR_W'(RECIP);
		end
		if (adv.s8) begin
			if (CMP_W'(quot) > CMP_W'(CXW_WEIGHT_MAX)) begin
				weight_s8 <= CXW_WEIGHT_W'(CXW_WEIGHT_MAX);
			end else begin
				weight_s8 <= CXW_WEIGHT_W'(quot);
			end
		end
	end

	assign weight = weight_s8;

endmodule

/* design/cie_xyz_weight_interpolator_top.sv */
// CIE 1931 2-degree x, y, z matching weights for one wavelength beat, linearly
// interpolated from an 81-point table. Depends on cxw_pkg and cxw_lane.
//
// One wavelength beat (nm, WAVE_FRAC_BITS fraction bits) in, one weight beat out,
// in order. The datapath is an eight-stage pipeline with a valid bit per stage, so a
// new beat is taken in every cycle for as long as m_tready stays high, and every
// beat passes through all stages in order on its way out. When the output stalls,
// empty stages keep filling and s_tready drops only once all eight hold a beat.
// Weights outside 380 nm up to but excluding 780 nm are zero and m_tuser is low.
module cie_xyz_weight_interpolator_top #(
	parameter int WAVE_FRAC_BITS   = cxw_pkg::CXW_WAVE_FRAC_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = cxw_pkg::CXW_WEIGHT_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [cxw_pkg::CXW_WAVE_W-1:0]   s_tdata,  // [15:0] wavelength_q4
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [cxw_pkg::CXW_TDATA_W-1:0]  m_tdata,  // [14:0] x_weight, [29:15] y_weight,
	                                                   // [44:30] z_weight, [47:45] zero
	output logic                             m_tuser   // [0] in_band
);
	import cxw_pkg::*;

	localparam int NST    = CXW_NSTAGE;
	localparam int D_W    = WAVE_FRAC_BITS + 3;
	localparam int SPAN   = CXW_STEP_NM << WAVE_FRAC_BITS;
	localparam int LO     = CXW_BAND_LOW_NM << WAVE_FRAC_BITS;
	localparam int HI     = CXW_BAND_HIGH_NM << WAVE_FRAC_BITS;
	// Wide enough for the whole input word and for the upper band edge.
	localparam int WL_W   = ($clog2(HI + 1) > CXW_WAVE_W) ? $clog2(HI + 1) : CXW_WAVE_W;
	localparam int OFF_W  = CXW_NM_OFF_W + WAVE_FRAC_BITS;
	// Interval index = nm offset / 5 via a reciprocal, exact below 2**CXW_NM_OFF_W.
	localparam int DIV_SH = CXW_NM_OFF_W + 3;
	localparam int DIV_M  = ((1 << DIV_SH) + 4) / 5;
	localparam int DM_W   = $clog2(DIV_M + 1);
	localparam int DQ_W   = CXW_NM_OFF_W + DM_W;

	logic [NST:1] vld_s;
	logic [NST:1] band_s;
	logic [NST:1] en;

	logic [OFF_W-1:0]      off_s1, off_s2;
	logic [CXW_IDX_W-1:0]  idx_s2, idx_s3;
	logic [D_W-1:0]        d_s3;

	logic [WL_W-1:0]       wl;
	logic                  band_in;
	logic [CXW_NM_OFF_W-1:0] nm_off;

	cxw_adv_t                adv;
	logic [CXW_WEIGHT_W-1:0] weight [CXW_NCH];

	// A stage loads when it is empty or its contents move on in the same cycle.
	always_comb begin
		en[NST] = !vld_s[NST] || m_tready;
		for (int k = NST - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign s_tready = en[1];
	assign adv      = '{s4: en[4], s5: en[5], s6: en[6], s7: en[7], s8: en[8]};

	assign wl      = WL_W'(s_tdata);
	assign band_in = (wl >= WL_W'(LO)) && (wl < WL_W'(HI));
	assign nm_off  = off_s1[OFF_W-1:WAVE_FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			band_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1]  <= s_tvalid;
				band_s[1] <= band_in;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld_s[k]  <= vld_s[k-1];
					band_s[k] <= band_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			// Out-of-band samples look up interval zero; the output masks them anyway.
			off_s1 <= band_in ? OFF_W'(wl - WL_W'(LO)) : '0;
		end
		if (en[2]) begin
			off_s2 <= off_s1;
			idx_s2 <= CXW_IDX_W'((DQ_W'(nm_off) * DQ_W'(DIV_M)) >> DIV_SH);
		end
		if (en[3]) begin
			idx_s3 <= idx_s2;
			d_s3   <= D_W'(off_s2 - OFF_W'(idx_s2) * OFF_W'(SPAN));
		end
	end

	for (genvar c = 0; c < CXW_NCH; c++) begin : g_lane
		cxw_lane #(
			.WAVE_FRAC_BITS   (WAVE_FRAC_BITS),
			.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
			.CHANNEL          (c)
		) u_lane (
			.clk    (clk),
			.adv    (adv),
			.idx    (idx_s3),
			.d      (d_s3),
			.weight (weight[c])
		);
	end

	assign m_tvalid = vld_s[NST];
	assign m_tuser  = band_s[NST];
	assign m_tdata  = band_s[NST]
		? {{(CXW_TDATA_W - CXW_NCH * CXW_WEIGHT_W){1'b0}},
		   weight[CXW_CH_Z], weight[CXW_CH_Y], weight[CXW_CH_X]}
		: '0;

	// With the output always ready, no stage ever holds back the input.
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled although the output side is ready");

	// Out-of-band beats carry zero weights.
	a_zero_out_of_band: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("nonzero weights on an out-of-band beat");

	// An accepted beat reaches the output if m_tready stays high while it passes through the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
		##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("beat lost in the pipeline");

endmodule
